### rtl/tw_odo_pkg.sv
// shared types, constants and tables for the three wheel odometry block
package tw_odo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ROT_IW           = 5;
    localparam int VW               = 56;
    localparam int DW               = 21;
    localparam int PW               = 48;
    localparam int AW               = 88;

    localparam logic [31:0] INV_GAIN        = 32'h9B74EDA8;
    localparam logic [31:0] DIST_RST        = 32'd26843546;
    localparam logic [31:0] TURN_RST        = 32'd87517160;
    localparam logic [31:0] COR_RST         = 32'd0;
    localparam logic [19:0] LIM_RST         = 20'd4096;

    localparam logic [7:0] REG_DIST_PER_TICK       = 8'd0;
    localparam logic [7:0] REG_TURN_PER_TICK_DIFF  = 8'd1;
    localparam logic [7:0] REG_CENTER_OFFSET_RATIO = 8'd2;
    localparam logic [7:0] REG_MAX_TICK_STEP       = 8'd3;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] center_count;
    } smp_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading_out;
        logic               skipped;
    } res_item_t;

    typedef enum logic [2:0] {
        MUL_DTH,
        MUL_HALF,
        MUL_FWD,
        MUL_SIDE,
        MUL_GX,
        MUL_GY
    } mul_op_t;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_RND
    } mul_ph_t;

    typedef struct packed {
        logic              load_smp;
        logic              clear;
        logic              lat_mul;
        logic              lat_sub;
        logic              mul_en;
        mul_ph_t           mul_ph;
        mul_op_t           mul_op;
        logic              quad;
        logic              rot;
        logic [ROT_IW-1:0] rot_idx;
        logic              acc;
        logic              load_res;
    } dp_cmd_t;

    typedef struct packed {
        logic too_big;
    } dp_sts_t;

    function automatic logic [31:0] atan_lookup(input logic [ROT_IW-1:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

### rtl/tw_odo_ctrl.sv
// sequencer for one odometry item: deltas, multiplies, cordic, accumulate
module tw_odo_ctrl #(
    parameter int CORDIC_STEPS = tw_odo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                smp_valid,
    input  logic                smp_kind,
    output logic                smp_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output tw_odo_pkg::dp_cmd_t cmd,
    input  tw_odo_pkg::dp_sts_t sts
);
    import tw_odo_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK  = 9'b000000010,
        S_LATM = 9'b000000100,
        S_LATS = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_QUAD = 9'b000100000,
        S_ROT  = 9'b001000000,
        S_ACC  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    mul_ph_t           ph_reg, ph_next;
    mul_op_t           op_reg, op_next;
    logic [ROT_IW-1:0] rot_reg, rot_next;
    logic              res_valid_reg, res_valid_next;

    assign smp_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        op_next        = op_reg;
        rot_next       = rot_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        cmd.mul_ph     = ph_reg;
        cmd.mul_op     = op_reg;
        cmd.rot_idx    = rot_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (smp_valid)
                begin
                    if (smp_kind)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.load_smp = 1'b1;
                        state_next   = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                state_next = sts.too_big ? S_DONE : S_LATM;
            end
            S_LATM:
            begin
                cmd.lat_mul = 1'b1;
                state_next  = S_LATS;
            end
            S_LATS:
            begin
                cmd.lat_sub = 1'b1;
                op_next     = MUL_DTH;
                ph_next     = PH_LO;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                unique case (ph_reg)
                    PH_LO: ph_next = PH_HI;
                    PH_HI: ph_next = PH_RND;
                    default:
                    begin
                        ph_next = PH_LO;
                        unique case (op_reg)
                            MUL_DTH:  op_next = MUL_HALF;
                            MUL_HALF: op_next = MUL_FWD;
                            MUL_FWD:  op_next = MUL_SIDE;
                            MUL_SIDE: op_next = MUL_GX;
                            MUL_GX:   op_next = MUL_GY;
                            default:  state_next = S_QUAD;
                        endcase
                    end
                endcase
            end
            S_QUAD:
            begin
                cmd.quad   = 1'b1;
                rot_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (rot_reg == ROT_IW'(CORDIC_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    rot_next = rot_reg + 1'b1;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.load_res   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_LO;
            op_reg        <= MUL_DTH;
            rot_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            op_reg        <= op_next;
            rot_reg       <= rot_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

### rtl/tw_odo_dp.sv
// datapath: config, stored counts, shared multiplier, cordic and pose
module tw_odo_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tw_odo_pkg::dp_cmd_t   cmd,
    output tw_odo_pkg::dp_sts_t   sts,
    input  tw_odo_pkg::smp_item_t smp,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output tw_odo_pkg::res_item_t res
);
    import tw_odo_pkg::*;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

    logic [31:0]        dist_reg, turn_reg;
    logic signed [31:0] cor_reg;
    logic [19:0]        lim_reg;

    logic [31:0]        last_l_reg, last_r_reg, last_c_reg;
    logic signed [DW-1:0] dl_reg, dr_reg, dc_reg;
    logic               skip_reg;
    logic signed [53:0] latm_reg;
    logic signed [VW-1:0] lat_reg;
    logic [VW-1:0]      mag_reg;
    logic               neg_reg;
    logic [AW-1:0]      acc_reg;
    logic [31:0]        dth_reg, half_reg;
    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [PW-1:0] pose_x_reg, pose_y_reg;
    logic [31:0]        head_reg;
    res_item_t          res_reg;

    // per-wheel deltas, right count negated
    logic [31:0] nl, nr, nc, d_l, d_r, d_c;
    logic        big;

    function automatic logic over_lim(input logic [31:0] d, input logic [19:0] lim);
        logic signed [32:0] ds;
        logic signed [32:0] ls;
        ds = {d[31], d};
        ls = {13'd0, lim};
        return (ds > ls) || (ds < -ls);
    endfunction

    assign nl  = smp.left_count;
    assign nr  = 32'd0 - smp.right_count;
    assign nc  = smp.center_count;
    assign d_l = nl - last_l_reg;
    assign d_r = nr - last_r_reg;
    assign d_c = nc - last_c_reg;
    assign big = over_lim(d_l, lim_reg) || over_lim(d_r, lim_reg) || over_lim(d_c, lim_reg);

    assign sts.too_big = skip_reg;

    logic signed [DW:0] diff, sum;
    assign diff = {dr_reg[DW-1], dr_reg} - {dl_reg[DW-1], dl_reg};
    assign sum  = {dr_reg[DW-1], dr_reg} + {dl_reg[DW-1], dl_reg};

    logic signed [53:0] diff_x, cor_x;
    assign diff_x = 54'(diff);
    assign cor_x  = 54'(cor_reg);

    // shared multiply with round to nearest, ties away from zero
    logic signed [VW-1:0] mv;
    logic [31:0]          mu;
    logic [5:0]           msh;
    logic [VW-1:0]        mag_w;
    logic [63:0]          plo;
    logic [VW-1:0]        phi;
    logic [AW-1:0]        rnd_sum, rnd_q;
    logic [VW-1:0]        r56;
    logic signed [VW-1:0] mres;

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_DTH:  begin mv = VW'(diff); mu = turn_reg; msh = 6'd8;  end
            MUL_HALF: begin mv = VW'(diff); mu = turn_reg; msh = 6'd9;  end
            MUL_FWD:  begin mv = VW'(sum);  mu = dist_reg; msh = 6'd13; end
            MUL_SIDE: begin mv = lat_reg;   mu = dist_reg; msh = 6'd36; end
            MUL_GX:   begin mv = x_reg;     mu = INV_GAIN; msh = 6'd32; end
            default:  begin mv = y_reg;     mu = INV_GAIN; msh = 6'd32; end
        endcase
    end

    assign mag_w   = mv[VW-1] ? (VW'(0) - mv) : mv;
    assign plo     = mag_w[31:0] * mu;
    assign phi     = mag_reg[VW-1:32] * mu;
    assign rnd_sum = acc_reg + (AW'(1) << (msh - 6'd1));
    assign rnd_q   = rnd_sum >> msh;
    assign r56     = rnd_q[VW-1:0];
    assign mres    = neg_reg ? (VW'(0) - r56) : r56;

    // cordic step terms
    logic signed [VW-1:0] xs, ys;
    logic signed [33:0]   at, za;
    logic [31:0]          zsum;
    assign xs   = x_reg >>> cmd.rot_idx;
    assign ys   = y_reg >>> cmd.rot_idx;
    assign at   = {2'b00, atan_lookup(cmd.rot_idx)};
    assign zsum = head_reg + half_reg;
    assign za   = 34'($signed(zsum));

    // saturating pose update
    logic signed [VW:0] sx, sy;
    logic signed [PW-1:0] px_sat, py_sat;
    assign sx = (VW+1)'(pose_x_reg) + (VW+1)'(x_reg);
    assign sy = (VW+1)'(pose_y_reg) + (VW+1)'(y_reg);

    always_comb
    begin
        priority if (sx > (VW+1)'(POS_MAX)) px_sat = POS_MAX;
        else if (sx < (VW+1)'(POS_MIN))    px_sat = POS_MIN;
        else                                px_sat = sx[PW-1:0];
        priority if (sy > (VW+1)'(POS_MAX)) py_sat = POS_MAX;
        else if (sy < (VW+1)'(POS_MIN))    py_sat = POS_MIN;
        else                                py_sat = sy[PW-1:0];
    end

    // config and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg   <= DIST_RST;
            turn_reg   <= TURN_RST;
            cor_reg    <= COR_RST;
            lim_reg    <= LIM_RST;
            last_l_reg <= '0;
            last_r_reg <= '0;
            last_c_reg <= '0;
            skip_reg   <= 1'b0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIST_PER_TICK:       dist_reg <= cfg_data;
                    REG_TURN_PER_TICK_DIFF:  turn_reg <= cfg_data;
                    REG_CENTER_OFFSET_RATIO: cor_reg  <= cfg_data;
                    REG_MAX_TICK_STEP:       lim_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (cmd.clear)
            begin
                last_l_reg <= '0;
                last_r_reg <= '0;
                last_c_reg <= '0;
                skip_reg   <= 1'b0;
                pose_x_reg <= '0;
                pose_y_reg <= '0;
                head_reg   <= '0;
            end
            else if (cmd.load_smp)
            begin
                last_l_reg <= nl;
                last_r_reg <= nr;
                last_c_reg <= nc;
                skip_reg   <= big;
            end
            else if (cmd.acc)
            begin
                pose_x_reg <= px_sat;
                pose_y_reg <= py_sat;
                head_reg   <= head_reg + dth_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_smp)
        begin
            dl_reg <= d_l[DW-1:0];
            dr_reg <= d_r[DW-1:0];
            dc_reg <= d_c[DW-1:0];
        end
        if (cmd.lat_mul)
        begin
            latm_reg <= diff_x * cor_x;
        end
        if (cmd.lat_sub)
        begin
            lat_reg <= (VW'(dc_reg) <<< 24) - VW'(latm_reg);
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_ph)
                PH_LO:
                begin
                    neg_reg <= mv[VW-1];
                    mag_reg <= mag_w;
                    acc_reg <= AW'(plo);
                end
                PH_HI:
                begin
                    acc_reg <= acc_reg + {phi, 32'd0};
                end
                default:
                begin
                    unique case (cmd.mul_op)
                        MUL_DTH:  dth_reg  <= mres[31:0];
                        MUL_HALF: half_reg <= mres[31:0];
                        MUL_FWD:  x_reg    <= mres;
                        MUL_SIDE: y_reg    <= mres;
                        MUL_GX:   x_reg    <= mres;
                        default:  y_reg    <= mres;
                    endcase
                end
            endcase
        end
        else if (cmd.quad)
        begin
            // fold angles beyond a quarter turn into range
            priority if (za > 34'sh040000000)
            begin
                x_reg <= -x_reg;
                y_reg <= -y_reg;
                z_reg <= za - 34'sh080000000;
            end
            else if (za < -34'sh040000000)
            begin
                x_reg <= -x_reg;
                y_reg <= -y_reg;
                z_reg <= za + 34'sh080000000;
            end
            else
            begin
                z_reg <= za;
            end
        end
        else if (cmd.rot)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.load_res)
        begin
            res_reg.pos_x       <= pose_x_reg;
            res_reg.pos_y       <= pose_y_reg;
            res_reg.heading_out <= head_reg;
            res_reg.skipped     <= skip_reg;
        end
    end

    assign res = res_reg;

endmodule

### rtl/three_wheel_odometry.sv
// top level of the three tracking wheel odometry block
// Each sample item carries absolute left, right and center encoder counts and
// yields one result item with the pose after it. The deltas are captured at
// acceptance; then come the limit check, the lateral multiply and subtract,
// six multiplies on the shared multiplier (each in low, high and rounding
// phases), the quadrant fold, CORDIC_STEPS rotation iterations, the
// accumulate and the load of the result register. A clear item goes straight
// to the result load; a rejected sample (any tick change above max_tick_step)
// goes to it from the limit check. One item is worked on at a time; the
// next item is accepted as soon as the previous one has moved into the result
// register, even if that result is still waiting on res_ready.
// Configuration writes are always taken; write them only while idle.
// Register indexes beyond max_tick_step are ignored.
module three_wheel_odometry #(
    parameter int CORDIC_STEPS = tw_odo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // sample items
    input  logic                  smp_valid,
    output logic                  smp_ready,
    input  tw_odo_pkg::smp_item_t smp,
    // result items
    output logic                  res_valid,
    input  logic                  res_ready,
    output tw_odo_pkg::res_item_t res,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import tw_odo_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // registers live in the datapath and can take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: owns the handshakes and steps the datapath
    tw_odo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_kind  (smp.kind),
        .smp_ready (smp_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: deltas, shared multiplier, cordic, saturating pose
    tw_odo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .smp       (smp),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

endmodule

### rtl/tw_odo_chk.sv
// port-level checks for the odometry block, bound to the top level
module tw_odo_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  smp_valid,
    input logic                  smp_ready,
    input tw_odo_pkg::smp_item_t smp,
    input logic                  res_valid,
    input logic                  res_ready,
    input tw_odo_pkg::res_item_t res
);
    import tw_odo_pkg::*;

    // a waiting result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // one item at a time: no accept right after a sample accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready && !smp.kind |=> !smp_ready)
        else $error("second item taken while busy");

    // a clear item taken while no result waits reports a zero pose
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready && smp.kind && !res_valid |=> ##1
        (res_valid && res.pos_x == '0 && res.pos_y == '0 &&
         res.heading_out == '0 && !res.skipped))
        else $error("clear item did not report zero pose");

endmodule

bind three_wheel_odometry tw_odo_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp       (smp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
